>>> rtl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants of the framed command receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

  localparam int unsigned NumRegs    = 8;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned CountW     = 5;
  localparam int unsigned CapDepth   = 8;
  localparam int unsigned CapIdxW    = 3;

  localparam logic [CountW-1:0] TimeLen     = 5'd3;
  localparam logic [CountW-1:0] DateLen     = 5'd4;
  localparam logic [CountW-1:0] MeasureLen  = 5'd26;
  localparam logic [CountW-1:0] MeasLoFirst = 5'd16;
  localparam logic [CountW-1:0] MeasLoLast  = 5'd21;
  localparam logic [CountW-1:0] MeasHiFirst = 5'd24;
  localparam logic [CountW-1:0] MeasHiLast  = 5'd25;
  localparam logic [CountW-1:0] MeasHiShift = 5'd18;
  localparam logic [7:0]        DateYearOffset = 8'd100;

  // register indexes
  localparam logic [RegIdxW-1:0] RegStart   = 3'd0;
  localparam logic [RegIdxW-1:0] RegTime    = 3'd1;
  localparam logic [RegIdxW-1:0] RegDate    = 3'd2;
  localparam logic [RegIdxW-1:0] RegWifi    = 3'd3;
  localparam logic [RegIdxW-1:0] RegCloud   = 3'd4;
  localparam logic [RegIdxW-1:0] RegAck     = 3'd5;
  localparam logic [RegIdxW-1:0] RegNack    = 3'd6;
  localparam logic [RegIdxW-1:0] RegMeasure = 3'd7;

  // message kinds
  localparam logic [2:0] KindTime    = 3'd0;
  localparam logic [2:0] KindDate    = 3'd1;
  localparam logic [2:0] KindWifi    = 3'd2;
  localparam logic [2:0] KindCloud   = 3'd3;
  localparam logic [2:0] KindAck     = 3'd4;
  localparam logic [2:0] KindNack    = 3'd5;
  localparam logic [2:0] KindMeasure = 3'd6;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] set_time_code;
    logic [7:0] set_date_code;
    logic [7:0] wifi_code;
    logic [7:0] cloud_code;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [7:0] measure_code;
  } fcr_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [3:0]  len;
  } fcr_result_t;

endpackage

`default_nettype wire

>>> rtl/framed_command_receiver_core.sv
// ----------------------------------------------------------------------------
// framed_command_receiver_core
// Byte-serial frame decoder: one received byte per item, at most one result per frame.
// ----------------------------------------------------------------------------
// A result is valid in the cycle after the frame's last byte is taken.
// Throughput: one byte per cycle; set by the single parser state update.
// A byte is taken whenever the result register is empty or being emptied.
// Reset: parser hunts for the start byte, command codes return to defaults,
// result register empty. Capture bytes are not reset.
`default_nettype none

module framed_command_receiver_core
  import fcr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [2:0]          msg_kind_o,
  output logic      [63:0]         payload_o,
  output logic      [3:0]          payload_len_o
);

  fcr_cfg_t    cfg;
  fcr_result_t result;
  logic        accept;
  logic        free;

  assign in_ready_o = free;
  assign accept     = in_valid_i & free;

  fcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  fcr_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .result_i      (result),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .free_o        (free),
    .msg_kind_o    (msg_kind_o),
    .payload_o     (payload_o),
    .payload_len_o (payload_len_o)
  );

endmodule

`default_nettype wire

>>> rtl/fcr_regs.sv
// ----------------------------------------------------------------------------
// fcr_regs
// Command code register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_regs
  import fcr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output fcr_cfg_t                 cfg_o
);

  logic [7:0] regs_q [NumRegs];
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ApbAddrW-1:2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegStart]   <= 8'h7E;
      regs_q[RegTime]    <= 8'd1;
      regs_q[RegDate]    <= 8'd2;
      regs_q[RegWifi]    <= 8'd3;
      regs_q[RegCloud]   <= 8'd4;
      regs_q[RegAck]     <= 8'd5;
      regs_q[RegNack]    <= 8'd6;
      regs_q[RegMeasure] <= 8'd7;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[7:0];
    end
  end

  assign prdata = {24'd0, regs_q[idx]};

  assign cfg_o.start_code    = regs_q[RegStart];
  assign cfg_o.set_time_code = regs_q[RegTime];
  assign cfg_o.set_date_code = regs_q[RegDate];
  assign cfg_o.wifi_code     = regs_q[RegWifi];
  assign cfg_o.cloud_code    = regs_q[RegCloud];
  assign cfg_o.ack_code      = regs_q[RegAck];
  assign cfg_o.nack_code     = regs_q[RegNack];
  assign cfg_o.measure_code  = regs_q[RegMeasure];

endmodule

`default_nettype wire

>>> rtl/fcr_parser.sv
// ----------------------------------------------------------------------------
// fcr_parser
// Frame parser: hunt, command decode, payload capture and result build.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_parser
  import fcr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire fcr_cfg_t   cfg_i,
  output fcr_result_t     result_o
);

  typedef enum logic [2:0] {
    ModeHunt    = 3'd0,
    ModeRoute   = 3'd1,
    ModeTime    = 3'd2,
    ModeDate    = 3'd3,
    ModeWifi    = 3'd4,
    ModeCloud   = 3'd5,
    ModeMeasure = 3'd6
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        cap_q [CapDepth];
  logic              cap_we;
  logic [CapIdxW-1:0] cap_idx;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] meas_hi_idx;
  logic [7:0]        b;

  assign b           = rx_byte_i;
  assign count_inc   = count_q + 5'd1;
  assign meas_hi_idx = count_q - MeasHiShift;

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    cap_we   = 1'b0;
    cap_idx  = count_q[CapIdxW-1:0];
    result_o = '0;
    case (mode_q)
      ModeRoute: begin
        count_d = '0;
        if (b == cfg_i.set_time_code) begin
          mode_d = ModeTime;
        end else if (b == cfg_i.set_date_code) begin
          mode_d = ModeDate;
        end else if (b == cfg_i.wifi_code) begin
          mode_d = ModeWifi;
        end else if (b == cfg_i.cloud_code) begin
          mode_d = ModeCloud;
        end else if (b == cfg_i.ack_code) begin
          mode_d         = ModeHunt;
          result_o.valid = 1'b1;
          result_o.kind  = KindAck;
        end else if (b == cfg_i.nack_code) begin
          mode_d         = ModeHunt;
          result_o.valid = 1'b1;
          result_o.kind  = KindNack;
        end else if (b == cfg_i.measure_code) begin
          mode_d = ModeMeasure;
        end else begin
          mode_d = ModeHunt;
        end
      end
      ModeTime: begin
        cap_we  = 1'b1;
        count_d = count_inc;
        if (count_inc >= TimeLen) begin
          count_d          = '0;
          mode_d           = ModeHunt;
          result_o.valid   = 1'b1;
          result_o.kind    = KindTime;
          result_o.payload = {40'd0, b, cap_q[1], cap_q[0]};
          result_o.len     = 4'd3;
        end
      end
      ModeDate: begin
        cap_we  = 1'b1;
        count_d = count_inc;
        if (count_inc >= DateLen) begin
          count_d          = '0;
          mode_d           = ModeHunt;
          result_o.valid   = 1'b1;
          result_o.kind    = KindDate;
          result_o.payload = {32'd0, b, 8'(cap_q[2] - DateYearOffset),
                              8'(cap_q[1] + 8'd1), cap_q[0]};
          result_o.len     = 4'd4;
        end
      end
      ModeWifi, ModeCloud: begin
        count_d          = '0;
        mode_d           = ModeHunt;
        result_o.valid   = 1'b1;
        result_o.kind    = (mode_q == ModeWifi) ? KindWifi : KindCloud;
        result_o.payload = {56'd0, b};
        result_o.len     = 4'd1;
      end
      ModeMeasure: begin
        if (count_q >= MeasLoFirst && count_q <= MeasLoLast) begin
          cap_we  = 1'b1;
          cap_idx = count_q[CapIdxW-1:0];
        end else if (count_q == MeasHiFirst || count_q == MeasHiLast) begin
          cap_we  = 1'b1;
          cap_idx = meas_hi_idx[CapIdxW-1:0];
        end
        count_d = count_inc;
        if (count_inc >= MeasureLen) begin
          count_d          = '0;
          mode_d           = ModeHunt;
          result_o.valid   = 1'b1;
          result_o.kind    = KindMeasure;
          result_o.payload = {b, cap_q[6], cap_q[5], cap_q[4],
                              cap_q[3], cap_q[2], cap_q[1], cap_q[0]};
          result_o.len     = 4'd8;
        end
      end
      default: begin
        mode_d  = (b == cfg_i.start_code) ? ModeRoute : ModeHunt;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeHunt;
      count_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && cap_we) begin
      cap_q[cap_idx] <= b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fcr_out_reg.sv
// ----------------------------------------------------------------------------
// fcr_out_reg
// Result register with valid/ready handshake towards the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_out_reg
  import fcr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire fcr_result_t result_i,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output logic       free_o,
  output logic [2:0] msg_kind_o,
  output logic [63:0] payload_o,
  output logic [3:0] payload_len_o
);

  logic        valid_q;
  logic [2:0]  kind_q;
  logic [63:0] payload_q;
  logic [3:0]  len_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i && result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && result_i.valid) begin
      kind_q    <= result_i.kind;
      payload_q <= result_i.payload;
      len_q     <= result_i.len;
    end
  end

  assign out_valid_o   = valid_q;
  assign msg_kind_o    = kind_q;
  assign payload_o     = payload_q;
  assign payload_len_o = len_q;

endmodule

`default_nettype wire

>>> rtl/fcr_checker.sv
// ----------------------------------------------------------------------------
// fcr_checker
// Port-level checks of the framed command receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_checker
  import fcr_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pwrite,
  input wire logic [ApbAddrW-1:0] paddr,
  input wire logic [ApbDataW-1:0] pwdata,
  input wire logic [ApbDataW-1:0] prdata,
  input wire logic                pready,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic [7:0]          rx_byte_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [2:0]          msg_kind_o,
  input wire logic [63:0]         payload_o,
  input wire logic [3:0]          payload_len_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_o))
    else $error("result dropped while stalled");

  // a fresh result needs an item taken the cycle before
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(in_valid_i && in_ready_o))
    else $error("result without item");

  // empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // length follows the kind
  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (msg_kind_o == KindTime && payload_len_o == 4'd3) ||
      (msg_kind_o == KindDate && payload_len_o == 4'd4) ||
      (msg_kind_o == KindWifi && payload_len_o == 4'd1) ||
      (msg_kind_o == KindCloud && payload_len_o == 4'd1) ||
      (msg_kind_o == KindAck && payload_len_o == 4'd0) ||
      (msg_kind_o == KindNack && payload_len_o == 4'd0) ||
      (msg_kind_o == KindMeasure && payload_len_o == 4'd8))
    else $error("payload length does not match kind");

  // for lengths up to four bytes, the upper four payload bytes are zero
  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_len_o <= 4'd4 |-> payload_o[63:32] == 32'd0)
    else $error("payload not zero-filled");

endmodule

bind framed_command_receiver_core fcr_checker u_fcr_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for framed_command_receiver_core.
// Sends received bytes as single frames: directed frames with the reset codes,
// then random frames under several sets of command codes written over APB.
// A byte-level model of the frame parser predicts each message, and every
// result the block gives is compared field by field in the order it arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import fcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [3:0]  len;
  } rx_msg_t;

  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [3:0]  len;
  } dir_row_t;

  typedef enum logic [2:0] {
    PM_HUNT, PM_ROUTE, PM_TIME, PM_DATE, PM_WIFI, PM_CLOUD, PM_MEAS
  } parse_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          msg_kind_o;
  logic [63:0]         payload_o;
  logic [3:0]          payload_len_o;

  // parser model state
  logic [7:0]        code_r [NumRegs];
  parse_mode_e       pmode;
  logic [CountW-1:0] pcount;
  logic [7:0]        cap [CapDepth];

  rx_msg_t pending_msgs[$];
  int      errors     = 0;
  int      bytes_sent = 0;
  bit      idle_on    = 1'b1;
  bit      hold_req   = 1'b0;

  // expected rows only where obvious; the date frame goes through the model
  dir_row_t dir_rows [24] = '{
    '{8'h00, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h05, 1'b1, KindAck,     64'h0,      4'd0},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h06, 1'b1, KindNack,    64'h0,      4'd0},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h03, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'hFF, 1'b1, KindWifi,    64'hFF,     4'd1},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h04, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h00, 1'b1, KindCloud,   64'h0,      4'd1},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h01, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h00, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'hFF, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h7E, 1'b1, KindTime,    64'h7EFF00, 4'd3},
    '{8'h7E, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h02, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h10, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'hFF, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h00, 1'b0, KindTime,    64'h0,      4'd0},
    '{8'h20, 1'b0, KindTime,    64'h0,      4'd0}
  };

  framed_command_receiver_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .msg_kind_o    (msg_kind_o),
    .payload_o     (payload_o),
    .payload_len_o (payload_len_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] pack_capture(input int n);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < n; i++) w[8*i +: 8] = cap[i];
    return w;
  endfunction

  // advances the parser model by one byte; returns 1 when a message completes
  function automatic bit decode_byte(input logic [7:0] b, output rx_msg_t m);
    logic [CountW-1:0] n;
    bit hit;
    hit = 1'b0;
    m   = '0;
    case (pmode)
      PM_ROUTE: begin
        pcount = '0;
        if (b == code_r[RegTime]) pmode = PM_TIME;
        else if (b == code_r[RegDate]) pmode = PM_DATE;
        else if (b == code_r[RegWifi]) pmode = PM_WIFI;
        else if (b == code_r[RegCloud]) pmode = PM_CLOUD;
        else if (b == code_r[RegAck]) begin
          pmode = PM_HUNT;
          m.kind = KindAck;
          hit = 1'b1;
        end else if (b == code_r[RegNack]) begin
          pmode = PM_HUNT;
          m.kind = KindNack;
          hit = 1'b1;
        end else if (b == code_r[RegMeasure]) pmode = PM_MEAS;
        else pmode = PM_HUNT;
      end
      PM_TIME, PM_DATE: begin
        n = (pmode == PM_TIME) ? TimeLen : DateLen;
        cap[pcount[CapIdxW-1:0]] = b;
        pcount = pcount + 1'b1;
        if (pcount >= n) begin
          if (pmode == PM_DATE) begin
            cap[1] = cap[1] + 8'd1;
            cap[2] = cap[2] - DateYearOffset;
          end
          m.kind    = (pmode == PM_TIME) ? KindTime : KindDate;
          m.payload = pack_capture(int'(n));
          m.len     = n[3:0];
          hit       = 1'b1;
          pcount    = '0;
          pmode     = PM_HUNT;
        end
      end
      PM_WIFI, PM_CLOUD: begin
        m.kind    = (pmode == PM_WIFI) ? KindWifi : KindCloud;
        m.payload = {56'h0, b};
        m.len     = 4'd1;
        hit       = 1'b1;
        pcount    = '0;
        pmode     = PM_HUNT;
      end
      PM_MEAS: begin
        if (pcount >= MeasLoFirst && pcount <= MeasLoLast)
          cap[CapIdxW'(pcount - MeasLoFirst)] = b;
        else if (pcount == MeasHiFirst || pcount == MeasHiLast)
          cap[CapIdxW'(pcount - MeasHiShift)] = b;
        pcount = pcount + 1'b1;
        if (pcount >= MeasureLen) begin
          m.kind    = KindMeasure;
          m.payload = pack_capture(CapDepth);
          m.len     = 4'd8;
          hit       = 1'b1;
          pcount    = '0;
          pmode     = PM_HUNT;
        end
      end
      default: begin
        pmode  = (b == code_r[RegStart]) ? PM_ROUTE : PM_HUNT;
        pcount = '0;
      end
    endcase
    return hit;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic offer_byte(input logic [7:0] b, input bit typed, input rx_msg_t typed_msg);
    rx_msg_t m;
    bit hit;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    hit = decode_byte(b, m);
    if (typed) pending_msgs.push_back(typed_msg);
    else if (hit) pending_msgs.push_back(m);
    bytes_sent++;
  endtask

  task automatic offer_rand(input logic [7:0] b);
    offer_byte(b, 1'b0, '0);
  endtask

  task automatic apb_access(input logic [RegIdxW-1:0] idx, input bit wr,
                            input logic [7:0] val, output logic [7:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata[7:0];
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_codes(input fcr_cfg_t c);
    logic [7:0] v;
    logic [7:0] rd;
    for (int i = 0; i < NumRegs; i++) begin
      v = c[8*(NumRegs-1-i) +: 8];
      apb_access(RegIdxW'(i), 1'b1, v, rd);
      code_r[i] = v;
      apb_access(RegIdxW'(i), 1'b0, 8'h00, rd);
      check_field("register readback", 64'(v), 64'(rd));
    end
  endtask

  // waits until the block has nothing left to give
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_frame();
    int sel;
    int plen;
    int ci;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      offer_rand(8'($urandom));
      return;
    end
    offer_rand(code_r[RegStart]);
    if (sel < 18) begin
      offer_rand(8'($urandom));
      plen = $urandom_range(0, 5);
    end else begin
      ci = $urandom_range(1, 7);
      offer_rand(code_r[ci]);
      case (RegIdxW'(ci))
        RegTime:    plen = TimeLen;
        RegDate:    plen = DateLen;
        RegWifi,
        RegCloud:   plen = 1;
        RegMeasure: plen = MeasureLen;
        default:    plen = 0;
      endcase
    end
    for (int i = 0; i < plen; i++) begin
      b = ($urandom_range(0, 7) == 0) ? code_r[RegStart] : 8'($urandom);
      offer_rand(b);
    end
  endtask

  task automatic random_block(input int n, input bit idle);
    int first;
    idle_on = idle;
    first = bytes_sent;
    while (bytes_sent - first < n) random_frame();
  endtask

  always @(negedge clk_i) begin
    rx_msg_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_msgs.size() == 0) begin
        $display("%0t: result with nothing expected, actual kind %0d payload %0h len %0d",
                 $time, msg_kind_o, payload_o, payload_len_o);
        errors++;
      end else begin
        e = pending_msgs.pop_front();
        check_field("msg_kind", 64'(e.kind), 64'(msg_kind_o));
        check_field("payload", e.payload, payload_o);
        check_field("payload_len", 64'(e.len), 64'(payload_len_o));
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        stall = 300;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(0, 18);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    fcr_cfg_t c;
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    code_r = '{8'h7E, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};
    pmode  = PM_HUNT;
    pcount = '0;
    for (int i = 0; i < CapDepth; i++) cap[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(dir_rows); i++)
      offer_byte(dir_rows[i].rx, dir_rows[i].typed,
                 '{dir_rows[i].kind, dir_rows[i].payload, dir_rows[i].len});
    random_block(230, 1'b1);
    drain();

    // start code equals the measurement code
    load_codes('{start_code: 8'hFF, set_time_code: 8'h00, set_date_code: 8'hFE,
                 wifi_code: 8'h80, cloud_code: 8'h7F, ack_code: 8'h01,
                 nack_code: 8'h55, measure_code: 8'hFF});
    hold_req = 1'b1;
    random_block(250, 1'b1);
    drain();

    // every command code equal: set time always wins
    load_codes('{start_code: 8'h00, set_time_code: 8'hA5, set_date_code: 8'hA5,
                 wifi_code: 8'hA5, cloud_code: 8'hA5, ack_code: 8'hA5,
                 nack_code: 8'hA5, measure_code: 8'hA5});
    random_block(120, 1'b0);
    drain();

    for (int p = 0; p < 3; p++) begin
      c = fcr_cfg_t'({$urandom, $urandom});
      load_codes(c);
      random_block(250, p != 2);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
